### sv/bmvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmvd_pkg
// Types and constants for the batch mean/variance core with depth tracking.
// ----------------------------------------------------------------------------
package bmvd_pkg;

    localparam int SCORE_W = 32;
    localparam int DEPTH_W = 12;
    localparam int LIMIT_W = 13;
    localparam int VAR_W   = 48;
    localparam int BS_W    = 11;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [0:0]         REG_BATCH_SIZE = 1'b0;
    localparam logic [BS_W-1:0]    BATCH_RESET    = 11'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 13'd10;
    localparam logic [DEPTH_W-1:0] DEPTH_BREAK    = 12'd50;
    localparam logic [LIMIT_W-1:0] DEPTH_STEP     = 13'd10;
    localparam logic [15:0]        RECIP_5        = 16'd52429;
    localparam int                 RECIP_SHIFT    = 18;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score_value;
        logic                      limit_exceeded;
        logic [DEPTH_W-1:0]        run_depth;
    } t_in_beat;

    typedef struct packed {
        logic                      batch_done;
        logic signed [SCORE_W-1:0] mean_score;
        logic [VAR_W-1:0]          score_variance;
        logic [DEPTH_W-1:0]        max_depth_seen;
        logic [LIMIT_W-1:0]        cur_limit;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV_MEAN,
        S_VAR,
        S_DIV_VAR,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

### sv/batch_mean_variance_depth_track_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// batch_mean_variance_depth_track_core
// Buffers scores, tracks the greatest qualifying depth and its limit, and
// gives the two-pass batch mean and population variance.
// ----------------------------------------------------------------------------
// A non-closing beat shows its output beat in the next cycle; such beats go one per cycle
//   unless the output stalls. A batch-closing beat needs n reads per pass on the single
//   read port plus two one-bit-per-cycle divisions; no beat is taken meanwhile.
// Reset: synchronous; clears fill count and depth, loads limit 10 and batch size 1024;
//   the score memory is not cleared.
module batch_mean_variance_depth_track_core #(
    parameter int MAX_BATCH = 1024
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  bmvd_pkg::t_in_beat              i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output bmvd_pkg::t_out_beat             o_out_data,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [bmvd_pkg::APB_AW-1:0]      paddr,
    input  wire [bmvd_pkg::APB_DW-1:0]      pwdata,
    output logic [bmvd_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import bmvd_pkg::*;

    localparam int AW     = $clog2(MAX_BATCH);
    localparam int N_W    = $clog2(MAX_BATCH + 1);
    localparam int SUM_W  = SCORE_W + AW + 1;
    localparam int ACC_W  = 2 * SCORE_W + AW + 1;
    localparam int DIV_W  = ACC_W - 16;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    logic [SCORE_W-1:0] score_mem [MAX_BATCH];

    t_state              r_state, n_state;
    logic [BS_W-1:0]     r_batch_size;
    logic [N_W-1:0]      r_fill;
    logic [DEPTH_W-1:0]  r_greatest, n_greatest;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic [N_W-1:0]      r_idx;
    logic [SCORE_W-1:0]  r_rd_data;
    logic                r_v1, r_v2, r_v3;
    logic signed [SUM_W-1:0] r_sum;
    logic                r_neg;
    logic [DIV_W-1:0]    r_dq;
    logic [N_W-1:0]      r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic signed [SCORE_W-1:0] r_mean;
    logic [SCORE_W-1:0]  r_abs;
    logic [2*SCORE_W-1:0] r_sq;
    logic [ACC_W-1:0]    r_acc;
    logic [VAR_W-1:0]    r_var;

    logic [N_W-1:0]      w_n;
    logic [31:0]         w_bs32;
    logic                w_slot_free;
    logic                w_accept;
    logic [N_W-1:0]      w_fill_next;
    logic                w_wr;
    logic                w_done;
    logic                w_pass;
    logic                w_issue;
    logic                w_pass_end;
    logic                w_div;
    logic                w_div_end;
    logic [N_W:0]        w_rem_sh;
    logic                w_ge;
    logic [N_W-1:0]      w_rem_next;
    logic [14:0]         w_six;
    logic [30:0]         w_prod;
    logic [SUM_W-1:0]    w_sum_mag;
    logic [DIV_W-1:0]    w_mean_q;
    logic signed [SCORE_W:0] w_diff;
    logic                w_cfg_wr;

    // effective batch size
    always_comb begin
        w_bs32 = 32'(r_batch_size);
        if (w_bs32 == 32'd0) begin
            w_n = N_W'(1);
        end else if (w_bs32 > 32'(MAX_BATCH)) begin
            w_n = N_W'(MAX_BATCH);
        end else begin
            w_n = N_W'(w_bs32);
        end
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_slot_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_wr        = w_accept && (r_fill < N_W'(MAX_BATCH));
    assign w_fill_next = w_wr ? r_fill + N_W'(1) : r_fill;
    assign w_done      = w_fill_next >= w_n;

    // depth tracking
    always_comb begin
        w_six      = {1'b0, i_in_data.run_depth, 2'b00} + {2'b00, i_in_data.run_depth, 1'b0};
        w_prod     = 31'(w_six) * 31'(RECIP_5);
        n_greatest = r_greatest;
        n_limit    = r_limit;
        if (!i_in_data.limit_exceeded && (i_in_data.run_depth > r_greatest)) begin
            n_greatest = i_in_data.run_depth;
            if (i_in_data.run_depth < DEPTH_BREAK) begin
                n_limit = LIMIT_W'(i_in_data.run_depth) + DEPTH_STEP;
            end else begin
                n_limit = LIMIT_W'(w_prod >> RECIP_SHIFT);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (w_pass_end) begin
                    n_state = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN: begin
                if (w_div_end) begin
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                if (w_pass_end) begin
                    n_state = S_DIV_VAR;
                end
            end
            S_DIV_VAR: begin
                if (w_div_end) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_pass = 1'b0;
        w_div  = 1'b0;
        case (r_state)
            S_SUM:      w_pass = 1'b1;
            S_VAR:      w_pass = 1'b1;
            S_DIV_MEAN: w_div  = 1'b1;
            S_DIV_VAR:  w_div  = 1'b1;
            default: begin
                w_pass = 1'b0;
                w_div  = 1'b0;
            end
        endcase
        w_issue    = w_pass && (r_idx < w_n);
        w_pass_end = w_pass && (r_idx >= w_n) && !r_v1 && !r_v2 && !r_v3;
        w_div_end  = w_div && (r_cnt == '0);
    end

    // shared restoring divider step
    always_comb begin
        w_rem_sh   = {r_rem, r_dq[DIV_W-1]};
        w_ge       = w_rem_sh >= {1'b0, w_n};
        w_rem_next = w_ge ? N_W'(w_rem_sh - {1'b0, w_n}) : N_W'(w_rem_sh);
        w_sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_mean_q   = r_neg ? -r_dq : r_dq;
        w_diff     = (SCORE_W+1)'($signed(r_rd_data)) - (SCORE_W+1)'(r_mean);
    end

    // score memory
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            score_mem[r_fill[AW-1:0]] <= i_in_data.score_value;
        end
        r_rd_data <= score_mem[r_idx[AW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_batch_size <= BATCH_RESET;
            r_fill       <= '0;
            r_greatest   <= '0;
            r_limit      <= LIMIT_RESET;
            r_out_valid  <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_batch_size <= pwdata[BS_W-1:0];
            end
            if (w_accept) begin
                r_fill     <= w_done ? '0 : w_fill_next;
                r_greatest <= n_greatest;
                r_limit    <= n_limit;
            end
            if ((w_accept && !w_done) || (r_state == S_OUT && w_slot_free)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1 && (r_state == S_VAR);
            r_v3 <= r_v2;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_done) begin
            r_out.batch_done     <= 1'b0;
            r_out.mean_score     <= '0;
            r_out.score_variance <= '0;
            r_out.max_depth_seen <= n_greatest;
            r_out.cur_limit      <= n_limit;
        end else if (r_state == S_OUT && w_slot_free) begin
            r_out.batch_done     <= 1'b1;
            r_out.mean_score     <= r_mean;
            r_out.score_variance <= r_var;
            r_out.max_depth_seen <= r_greatest;
            r_out.cur_limit      <= r_limit;
        end

        if (w_accept) begin
            r_idx <= '0;
            r_sum <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + N_W'(1);
        end else if (w_div_end) begin
            r_idx <= '0;
        end

        if (r_state == S_SUM && r_v1) begin
            r_sum <= r_sum + SUM_W'($signed(r_rd_data));
        end

        if (r_state == S_SUM && w_pass_end) begin
            r_neg <= r_sum[SUM_W-1];
            r_dq  <= DIV_W'(w_sum_mag);
            r_rem <= '0;
            r_cnt <= CNT_W'(DIV_W);
        end else if (r_state == S_VAR && w_pass_end) begin
            r_dq  <= r_acc[ACC_W-1:16];
            r_rem <= '0;
            r_cnt <= CNT_W'(DIV_W);
        end else if (w_div && !w_div_end) begin
            r_dq  <= {r_dq[DIV_W-2:0], w_ge};
            r_rem <= w_rem_next;
            r_cnt <= r_cnt - CNT_W'(1);
        end

        if (r_state == S_DIV_MEAN && w_div_end) begin
            r_mean <= $signed(w_mean_q[SCORE_W-1:0]);
            r_acc  <= '0;
        end else if (r_state == S_VAR && r_v3) begin
            r_acc <= r_acc + ACC_W'(r_sq);
        end

        if (r_v1) begin
            r_abs <= w_diff[SCORE_W] ? SCORE_W'(-w_diff) : SCORE_W'(w_diff);
        end
        if (r_v2) begin
            r_sq <= (2*SCORE_W)'(r_abs) * (2*SCORE_W)'(r_abs);
        end

        if (r_state == S_DIV_VAR && w_div_end) begin
            r_var <= (r_dq[DIV_W-1:VAR_W] != '0) ? '1 : r_dq[VAR_W-1:0];
        end
    end

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_BATCH_SIZE);
    always_comb begin
        if (paddr[2:2] == REG_BATCH_SIZE) begin
            prdata = APB_DW'(r_batch_size);
        end else begin
            prdata = '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
